// ----- hw/rtl/box_iou_best_match_core_defines.svh -----
// Assertion macros for the checker file of box_iou_best_match_core.
// Each macro expects signals clk and arst_n in the scope where it is used.
`ifndef BOX_IOU_BEST_MATCH_CORE_DEFINES_SVH
`define BOX_IOU_BEST_MATCH_CORE_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define BIOU_ASSERT_NOW(label, ante, cons, msg) label: assert property (@(posedge clk) \
	disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet during reset.
`define BIOU_ASSERT_NEXT(label, ante, cons, msg) label: assert property (@(posedge clk) \
	disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/biou_pkg.sv -----
// Shared constants for the box IoU best-match block.
// No dependencies; imported by the core, biou_div, biou_checker and the testbench.
package biou_pkg;

	// Parameter defaults
	localparam int MAX_TRACKS_DEF  = 32;
	localparam int COORD_BITS_DEF  = 16;

	// Fixed field widths
	localparam int SLOT_BITS  = 5;
	localparam int COUNT_BITS = 6;
	localparam int IOU_BITS   = 16;

	localparam logic [IOU_BITS-1:0] IOU_MAX = '1;

	// Item mode codes
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

endpackage

// ----- hw/rtl/box_iou_best_match_core.sv -----
// Box IoU best match. A mode 0 beat writes its box into track slot "slot" and
// gives no result; the block stays ready. A mode 1 beat is a query: the
// block walks slots 0 .. min(entries_in_use, MAX_TRACKS)-1, computes each
// slot's IoU with the query box in unsigned Q0.16 (inclusive pixel
// coordinates), and returns the best slot; a slot replaces the running best,
// which starts at start_iou, only on a strictly greater IoU, so the lower
// slot wins a tie. One shared signed multiplier forms the query area, each
// slot's area and the intersection; one restoring divider gives one IoU bit
// a cycle. A query runs S_QAREA, then per slot S_READ, S_LOAD, S_MUL_B,
// S_MUL_I, S_UNION, S_DECIDE, S_DIVIDE if the IoU needs the divider (overlap
// present and below one) and S_UPDATE, then S_FINISH, which holds until any
// previous result beat is taken. item_ready is low for the whole query; a
// finished result waits in the output register while the block accepts new
// beats. The track table has no reset: query only slots that were written.
module box_iou_best_match_core
	import biou_pkg::*;
#(
	parameter int MAX_TRACKS = MAX_TRACKS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic                         mode,
	input  logic [SLOT_BITS-1:0]         slot,
	input  logic signed [COORD_BITS-1:0] left,
	input  logic signed [COORD_BITS-1:0] top,
	input  logic signed [COORD_BITS-1:0] right,
	input  logic signed [COORD_BITS-1:0] bottom,
	input  logic [COUNT_BITS-1:0]        entries_in_use,
	input  logic [IOU_BITS-1:0]          start_iou,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [SLOT_BITS-1:0]         best_slot,
	output logic [IOU_BITS-1:0]          best_iou,
	output logic                         found
);

	localparam int CB   = COORD_BITS;
	localparam int AW   = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
	localparam int NW   = $clog2(MAX_TRACKS + 1);
	localparam int DW   = CB + 2;
	localparam int PW   = 2 * DW;
	localparam int UW   = PW + 2;
	localparam int EW   = 4 * CB;

	typedef enum logic [3:0] {
		S_IDLE,
		S_QAREA,
		S_READ,
		S_LOAD,
		S_MUL_B,
		S_MUL_I,
		S_UNION,
		S_DECIDE,
		S_DIVIDE,
		S_UPDATE,
		S_FINISH
	} state_t;

	state_t state_q;

	// Query box and walk state
	logic signed [CB-1:0] q_l_q, q_t_q, q_r_q, q_b_q;
	logic signed [DW-1:0] q_w_q, q_h_q;
	logic signed [DW-1:0] b_w_q, b_h_q, i_w_q, i_h_q;
	logic signed [PW-1:0] area_q_q, area_b_q, inter_q;
	logic signed [UW-1:0] uni_q;
	logic [NW-1:0]        n_q, idx_q;
	logic [IOU_BITS-1:0]  best_q, v_q;
	logic [SLOT_BITS-1:0] best_slot_q;
	logic                 found_q;

	logic accept;
	logic ram_we;
	logic [EW-1:0] rd_data;
	logic signed [CB-1:0] r_l, r_t, r_r, r_b;
	logic signed [CB-1:0] min_r, max_l, min_b, max_t;
	logic signed [DW-1:0] iw_raw, ih_raw;
	logic signed [DW-1:0] mul_x, mul_y;
	logic signed [PW-1:0] mul_p;
	logic uni_pos, inter_zero, inter_ge;
	logic div_start, div_done;
	logic [IOU_BITS-1:0] div_quo;

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign ram_we     = accept && (mode == MODE_WRITE) && (32'(slot) < 32'(MAX_TRACKS));

	// Track table
	biou_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_TRACKS)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (AW'(slot)),
		.wr_data ({left, top, right, bottom}),
		.rd_en   (state_q == S_READ),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	assign r_l = rd_data[4*CB-1 -: CB];
	assign r_t = rd_data[3*CB-1 -: CB];
	assign r_r = rd_data[2*CB-1 -: CB];
	assign r_b = rd_data[CB-1:0];

	// Overlap edges of the query and the slot box
	assign min_r  = (q_r_q < r_r) ? q_r_q : r_r;
	assign max_l  = (q_l_q > r_l) ? q_l_q : r_l;
	assign min_b  = (q_b_q < r_b) ? q_b_q : r_b;
	assign max_t  = (q_t_q > r_t) ? q_t_q : r_t;
	assign iw_raw = DW'(min_r) - DW'(max_l) + DW'(1);
	assign ih_raw = DW'(min_b) - DW'(max_t) + DW'(1);

	// Shared multiplier operand select
	always_comb begin
		case (state_q)
			S_QAREA: begin
				mul_x = q_w_q;
				mul_y = q_h_q;
			end
			S_MUL_B: begin
				mul_x = b_w_q;
				mul_y = b_h_q;
			end
			default: begin
				mul_x = i_w_q;
				mul_y = i_h_q;
			end
		endcase
	end
	assign mul_p = mul_x * mul_y;

	// Classify the union and intersection before dividing
	assign uni_pos    = !uni_q[UW-1] && (uni_q != '0);
	assign inter_zero = (inter_q == '0);
	assign inter_ge   = (UW'(inter_q) >= uni_q);
	assign div_start  = (state_q == S_DECIDE) && uni_pos && !inter_zero && !inter_ge;

	biou_div #(
		.UW (UW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (UW'(inter_q)),
		.den    (uni_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			result_valid <= 1'b0;
			best_slot    <= '0;
			best_iou     <= '0;
			found        <= 1'b0;
		end else begin
			// Drop a taken result beat unless a new one replaces it
			if (result_valid && result_ready && (state_q != S_FINISH)) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && (mode == MODE_QUERY)) begin
						state_q <= S_QAREA;
					end
				end
				S_QAREA:  state_q <= S_READ;
				S_READ:   state_q <= (idx_q == n_q) ? S_FINISH : S_LOAD;
				S_LOAD:   state_q <= S_MUL_B;
				S_MUL_B:  state_q <= S_MUL_I;
				S_MUL_I:  state_q <= S_UNION;
				S_UNION:  state_q <= S_DECIDE;
				S_DECIDE: state_q <= div_start ? S_DIVIDE : S_UPDATE;
				S_DIVIDE: begin
					if (div_done) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: state_q <= S_READ;
				S_FINISH: begin
					// Hold until the previous result beat is gone
					if (!result_valid || result_ready) begin
						result_valid <= 1'b1;
						best_slot    <= best_slot_q;
						best_iou     <= best_q;
						found        <= found_q;
						state_q      <= S_IDLE;
					end else begin
						result_valid <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					q_l_q       <= left;
					q_t_q       <= top;
					q_r_q       <= right;
					q_b_q       <= bottom;
					q_w_q       <= DW'(right) - DW'(left) + DW'(1);
					q_h_q       <= DW'(bottom) - DW'(top) + DW'(1);
					n_q         <= (32'(entries_in_use) > 32'(MAX_TRACKS)) ?
					               NW'(MAX_TRACKS) : NW'(entries_in_use);
					idx_q       <= '0;
					best_q      <= start_iou;
					best_slot_q <= '0;
					found_q     <= 1'b0;
				end
			end
			S_QAREA: area_q_q <= mul_p;
			S_LOAD: begin
				b_w_q <= DW'(r_r) - DW'(r_l) + DW'(1);
				b_h_q <= DW'(r_b) - DW'(r_t) + DW'(1);
				i_w_q <= iw_raw[DW-1] ? '0 : iw_raw;
				i_h_q <= ih_raw[DW-1] ? '0 : ih_raw;
			end
			S_MUL_B: area_b_q <= mul_p;
			S_MUL_I: inter_q <= mul_p;
			S_UNION: uni_q <= UW'(area_q_q) + UW'(area_b_q) - UW'(inter_q);
			S_DECIDE: begin
				// Empty union or no overlap scores zero; full overlap saturates
				if (!uni_pos || inter_zero) begin
					v_q <= '0;
				end else if (inter_ge) begin
					v_q <= IOU_MAX;
				end
			end
			S_DIVIDE: begin
				if (div_done) begin
					v_q <= div_quo;
				end
			end
			S_UPDATE: begin
				// Take the slot only on a strict win
				if (v_q > best_q) begin
					best_q      <= v_q;
					best_slot_q <= SLOT_BITS'(idx_q);
					found_q     <= 1'b1;
				end
				idx_q <= idx_q + NW'(1);
			end
			default: ;
		endcase
	end

endmodule

// ----- hw/rtl/biou_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; holds the track table of the box IoU block.
module biou_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry and read one entry into the registered rd_data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/biou_div.sv -----
// Restoring divider, one quotient bit a cycle, for the IoU fraction.
// Depends on biou_pkg (IOU_BITS). Requires num < den, den positive.
module biou_div
	import biou_pkg::*;
#(
	parameter int UW = 38
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [UW-1:0]       num,
	input  logic [UW-1:0]       den,
	output logic                done,
	output logic [IOU_BITS-1:0] quo
);

	localparam int CW = $clog2(IOU_BITS + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [UW-1:0] rem_q;
	logic [UW-1:0] den_q;
	logic [IOU_BITS-1:0] quo_q;

	logic [UW-1:0] rem_sh;
	logic          take;

	// Shift the remainder and try one subtraction
	assign rem_sh = {rem_q[UW-2:0], 1'b0};
	assign take   = (rem_sh >= den_q);

	// Step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(IOU_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? (rem_sh - den_q) : rem_sh;
			quo_q <= {quo_q[IOU_BITS-2:0], take};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- hw/rtl/biou_checker.sv -----
// Port-level checker for box_iou_best_match_core, attached by bind.
// Depends on biou_pkg and box_iou_best_match_core_defines.svh.
`include "box_iou_best_match_core_defines.svh"

module biou_checker
	import biou_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_valid,
	input logic                 item_ready,
	input logic                 mode,
	input logic                 result_valid,
	input logic                 result_ready,
	input logic [SLOT_BITS-1:0] best_slot,
	input logic [IOU_BITS-1:0]  best_iou,
	input logic                 found
);

	// Hold a stalled result beat
	`BIOU_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(best_slot) && $stable(best_iou) && $stable(found), "stalled result beat changed")

	// No match leaves the slot at zero
	`BIOU_ASSERT_NOW(a_miss_slot_zero, result_valid && !found, best_slot == '0, "best_slot nonzero without a match")

	// A match beats a floor of at least zero
	`BIOU_ASSERT_NOW(a_hit_nonzero, result_valid && found, best_iou != '0, "match reported with zero IoU")

	// A query keeps the block busy
	`BIOU_ASSERT_NEXT(a_query_busy, item_valid && item_ready && mode == MODE_QUERY, !item_ready, "ready right after a query beat")

	// A slot write leaves the block ready and gives no result
	`BIOU_ASSERT_NEXT(a_write_quiet, item_valid && item_ready && mode == MODE_WRITE, item_ready && !$rose(result_valid), "slot write stalled or made a result")

endmodule

bind box_iou_best_match_core biou_checker u_biou_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench for box_iou_best_match_core: loads track boxes, runs best-match queries and
// checks each result against an in-bench IoU predictor. Needs biou_pkg and the core RTL.
module tb;
	import biou_pkg::*;

	localparam int COORD_BITS   = COORD_BITS_DEF;
	localparam int MAX_TRACKS   = MAX_TRACKS_DEF;
	localparam int COUNT_TOP    = (1 << COUNT_BITS) - 1;
	localparam int RANDOM_BEATS = 600;
	localparam int MAX_GAP      = 8;
	localparam int TAIL_CYCLES  = 800;

	typedef enum int {BOX_NEAR, BOX_WILD, BOX_WIDE} box_kind_e;

	typedef struct {
		logic signed [COORD_BITS-1:0] l, t, r, b;
	} box_t;

	typedef struct {
		logic                  mode;
		logic [SLOT_BITS-1:0]  slot;
		box_t                  box;
		logic [COUNT_BITS-1:0] count;
		logic [IOU_BITS-1:0]   start;
		int                    gap;
		bit                    drain;
	} beat_t;

	typedef struct {
		logic [SLOT_BITS-1:0] slot;
		logic [IOU_BITS-1:0]  iou;
		logic                 found;
	} match_t;

	logic                         clk            = 1'b0;
	logic                         arst_n         = 1'b0;
	logic                         item_valid     = 1'b0;
	logic                         item_ready;
	logic                         mode           = 1'b0;
	logic [SLOT_BITS-1:0]         slot           = '0;
	logic signed [COORD_BITS-1:0] left           = '0;
	logic signed [COORD_BITS-1:0] top            = '0;
	logic signed [COORD_BITS-1:0] right          = '0;
	logic signed [COORD_BITS-1:0] bottom         = '0;
	logic [COUNT_BITS-1:0]        entries_in_use = '0;
	logic [IOU_BITS-1:0]          start_iou      = '0;
	logic                         result_valid;
	logic                         result_ready   = 1'b0;
	logic [SLOT_BITS-1:0]         best_slot;
	logic [IOU_BITS-1:0]          best_iou;
	logic                         found;

	// Stimulus side
	beat_t  pending_beats[$];
	box_t   planned_boxes[MAX_TRACKS];
	bit     [MAX_TRACKS-1:0] planned_mask = '0;
	bit     tx_burst = 1'b0;
	int     beats_total = 0;
	int     beats_taken = 0;
	longint cycle_limit = 20000;
	longint cycle_cnt = 0;

	// Predictor side
	box_t   track_boxes[MAX_TRACKS];
	match_t pending_matches[$];
	int     err_cnt = 0;

	// Driver and monitor working state
	beat_t  cur_beat;
	beat_t  next_beat;
	bit     staged = 1'b0;
	bit     bus_free;
	bit     launch;
	int     gap_cnt = 0;
	int     stall_cnt = 0;
	bit     rx_burst = 1'b0;
	match_t want;

	box_iou_best_match_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.mode           (mode),
		.slot           (slot),
		.left           (left),
		.top            (top),
		.right          (right),
		.bottom         (bottom),
		.entries_in_use (entries_in_use),
		.start_iou      (start_iou),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.best_slot      (best_slot),
		.best_iou       (best_iou),
		.found          (found)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// IoU of two boxes in Q0.16, inclusive coordinates, bit-serial division
	function automatic logic [IOU_BITS-1:0] pair_iou(box_t a, box_t b);
		longint al, at, ar, ab, bl, bt, br, bb;
		longint area_a, area_b, iw, ih, inter, uni, rem;
		logic [IOU_BITS-1:0] q;
		al = a.l; at = a.t; ar = a.r; ab = a.b;
		bl = b.l; bt = b.t; br = b.r; bb = b.b;
		area_a = (ar - al + 1) * (ab - at + 1);
		area_b = (br - bl + 1) * (bb - bt + 1);
		iw = ((ar < br) ? ar : br) - ((al > bl) ? al : bl) + 1;
		ih = ((ab < bb) ? ab : bb) - ((at > bt) ? at : bt) + 1;
		if (iw < 0) iw = 0;
		if (ih < 0) ih = 0;
		inter = iw * ih;
		uni = area_a + area_b - inter;
		if (uni <= 0) return '0;
		if (inter >= uni) return IOU_MAX;
		rem = inter;
		q = '0;
		for (int i = 0; i < IOU_BITS; i++) begin
			rem = rem << 1;
			q = {q[IOU_BITS-2:0], 1'b0};
			if (rem >= uni) begin
				rem = rem - uni;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	// Apply one accepted beat: store a track or predict the query's best match
	function automatic void track_step(beat_t bt);
		int     span;
		match_t m;
		logic [IOU_BITS-1:0] v;
		if (bt.mode == MODE_WRITE) begin
			track_boxes[bt.slot] = bt.box;
		end else begin
			span = (int'(bt.count) > MAX_TRACKS) ? MAX_TRACKS : int'(bt.count);
			m.slot = '0;
			m.iou = bt.start;
			m.found = 1'b0;
			for (int i = 0; i < span; i++) begin
				v = pair_iou(bt.box, track_boxes[i]);
				if (v > m.iou) begin
					m.iou = v;
					m.slot = SLOT_BITS'(i);
					m.found = 1'b1;
				end
			end
			pending_matches.insert(pending_matches.size(), m);
		end
	endfunction

	function automatic box_t mk_box(int l, int t, int r, int b);
		box_t bx;
		bx.l = COORD_BITS'(l);
		bx.t = COORD_BITS'(t);
		bx.r = COORD_BITS'(r);
		bx.b = COORD_BITS'(b);
		return bx;
	endfunction

	function automatic box_t rand_box(box_kind_e kind);
		int l, t, w, h;
		box_t bx;
		case (kind)
			BOX_NEAR: begin
				l = int'($urandom_range(0, 300)) - 150;
				t = int'($urandom_range(0, 300)) - 150;
				w = int'($urandom_range(1, 60));
				h = int'($urandom_range(1, 60));
				// flip some boxes so widths or heights go negative
				if ($urandom_range(0, 9) == 0) w = -w;
				if ($urandom_range(0, 9) == 0) h = -h;
				bx = mk_box(l, t, l + w - 1, t + h - 1);
			end
			BOX_WIDE: begin
				bx = mk_box(int'($urandom_range(0, 31000)) - 32768,
					int'($urandom_range(0, 31000)) - 32768,
					1000 + int'($urandom_range(0, 31767)),
					1000 + int'($urandom_range(0, 31767)));
			end
			default: begin
				bx.l = COORD_BITS'($urandom);
				bx.t = COORD_BITS'($urandom);
				bx.r = COORD_BITS'($urandom);
				bx.b = COORD_BITS'($urandom);
			end
		endcase
		return bx;
	endfunction

	function automatic logic [IOU_BITS-1:0] rand_start();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) return '0;
		if (pick < 70) return IOU_BITS'($urandom_range(0, 40000));
		if (pick < 90) return IOU_BITS'($urandom);
		if (pick < 95) return IOU_MAX - 1'b1;
		return IOU_MAX;
	endfunction

	// Number of leading slots already written, the only ones a query may search
	function automatic int written_prefix();
		int n;
		n = 0;
		while (n < MAX_TRACKS && planned_mask[n]) n++;
		return n;
	endfunction

	// Queue one beat with its idle gap and extend the cycle budget
	function automatic void add_beat(logic md, logic [SLOT_BITS-1:0] sl, box_t bx,
		logic [COUNT_BITS-1:0] cnt, logic [IOU_BITS-1:0] st, bit hold);
		beat_t bt;
		int span;
		if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
		bt.mode = md;
		bt.slot = sl;
		bt.box = bx;
		bt.count = cnt;
		bt.start = st;
		bt.gap = tx_burst ? 0 : int'($urandom_range(0, MAX_GAP));
		bt.drain = hold;
		span = (int'(cnt) > MAX_TRACKS) ? MAX_TRACKS : int'(cnt);
		if (md == MODE_WRITE) begin
			planned_boxes[sl] = bx;
			planned_mask[sl] = 1'b1;
			cycle_limit += 4 * (bt.gap + 4);
		end else begin
			cycle_limit += 4 * (bt.gap + 4 + 24 * span + 3 + MAX_GAP + 2);
		end
		pending_beats.insert(pending_beats.size(), bt);
		beats_total++;
	endfunction

	function automatic void check_field(string what, int exp_v, int got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
			err_cnt++;
		end
	endfunction

	// Drive input beats from the pending queue, honoring gaps and drain points
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			mode <= MODE_WRITE;
			slot <= '0;
			left <= '0;
			top <= '0;
			right <= '0;
			bottom <= '0;
			entries_in_use <= '0;
			start_iou <= '0;
			staged = 1'b0;
			gap_cnt = 0;
		end else begin
			bus_free = !item_valid || item_ready;
			if (item_valid && item_ready) begin
				track_step(cur_beat);
				beats_taken++;
			end
			if (bus_free) begin
				if (!staged && pending_beats.size() > 0) begin
					next_beat = pending_beats.pop_front();
					staged = 1'b1;
					gap_cnt = next_beat.gap;
				end
				launch = 1'b0;
				if (staged) begin
					if (gap_cnt > 0)
						gap_cnt--;
					else if (!next_beat.drain || pending_matches.size() == 0)
						launch = 1'b1;
				end
				if (launch) begin
					cur_beat = next_beat;
					staged = 1'b0;
					mode <= next_beat.mode;
					slot <= next_beat.slot;
					left <= next_beat.box.l;
					top <= next_beat.box.t;
					right <= next_beat.box.r;
					bottom <= next_beat.box.b;
					entries_in_use <= next_beat.count;
					start_iou <= next_beat.start;
				end
				item_valid <= launch;
			end
		end
	end

	// Take result beats after a random stall and compare with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall_cnt = $urandom_range(0, MAX_GAP);
		end else begin
			if (result_valid && result_ready) begin
				if (pending_matches.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual slot %0d iou %0d found %0d",
						$time, best_slot, best_iou, found);
					err_cnt++;
				end else begin
					want = pending_matches.pop_front();
					check_field("best_slot", int'(want.slot), int'(best_slot));
					check_field("best_iou", int'(want.iou), int'(best_iou));
					check_field("found", int'(want.found), int'(found));
				end
				if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
				stall_cnt = rx_burst ? 0 : int'($urandom_range(0, MAX_GAP));
			end
			// count the stall down only while a result is actually waiting
			if (stall_cnt > 0) begin
				if (result_valid) stall_cnt--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin
		box_t      qb;
		box_kind_e kind;
		int        pfx, pick, cnt, wslot, s;
		bit        hold, big_done;
		big_done = 1'b0;

		// Directed: empty search, saturation, floors, negative areas, extremes, ties
		add_beat(MODE_QUERY, 5'd0, mk_box(0, 0, 0, 0), 6'd0, 16'd0, 1'b0);
		add_beat(MODE_WRITE, 5'd0, mk_box(10, 10, 19, 19), 6'd63, 16'hFFFF, 1'b0);
		add_beat(MODE_QUERY, 5'd31, mk_box(10, 10, 19, 19), 6'd1, 16'd0, 1'b0);
		add_beat(MODE_QUERY, 5'd0, mk_box(10, 10, 19, 19), 6'd1, IOU_MAX, 1'b0);
		add_beat(MODE_WRITE, 5'd1, mk_box(20, 0, 10, 9), 6'd0, 16'd0, 1'b0);
		add_beat(MODE_QUERY, 5'd0, mk_box(0, 0, 0, 0), 6'd2, 16'd0, 1'b0);
		add_beat(MODE_WRITE, 5'd2, mk_box(-32768, -32768, 32767, 32767), 6'd0, 16'd0, 1'b0);
		add_beat(MODE_QUERY, 5'd0, mk_box(-32768, -32768, 32767, 32767), 6'd3, 16'd0, 1'b0);
		add_beat(MODE_QUERY, 5'd0, mk_box(-32768, -32768, 0, 0), 6'd3, 16'd0, 1'b0);
		add_beat(MODE_WRITE, 5'd3, mk_box(15, 15, 24, 24), 6'd0, 16'd0, 1'b0);
		add_beat(MODE_WRITE, 5'd4, mk_box(10, 10, 19, 19), 6'd0, 16'd0, 1'b0);
		add_beat(MODE_QUERY, 5'd0, mk_box(10, 10, 19, 19), 6'd5, 16'd0, 1'b0);
		add_beat(MODE_QUERY, 5'd0, mk_box(12, 10, 21, 19), 6'd5, 16'd43690, 1'b0);
		add_beat(MODE_QUERY, 5'd0, mk_box(12, 10, 21, 19), 6'd5, 16'd43689, 1'b0);
		add_beat(MODE_WRITE, 5'd31, mk_box(32767, 32767, -32768, -32768), 6'd0, 16'd0, 1'b0);
		add_beat(MODE_WRITE, 5'd5, mk_box(-1, -1, -1, -1), 6'd0, 16'd0, 1'b0);
		add_beat(MODE_QUERY, 5'd0, mk_box(-1, -1, -1, -1), 6'd6, 16'd1, 1'b0);
		add_beat(MODE_QUERY, 5'd21, mk_box(11, 9, 20, 18), 6'd6, 16'd0, 1'b1);

		// Random: fill the table front to back, query mostly near stored boxes
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			pfx = written_prefix();
			hold = (n % 150) == 75;
			pick = $urandom_range(0, 99);
			if (pick < 75) kind = BOX_NEAR;
			else if (pick < 87) kind = BOX_WILD;
			else kind = BOX_WIDE;
			if ($urandom_range(0, 99) < 45) begin
				if (pfx < MAX_TRACKS && $urandom_range(0, 9) < 7)
					wslot = pfx;
				else
					wslot = $urandom_range(0, MAX_TRACKS - 1);
				add_beat(MODE_WRITE, SLOT_BITS'(wslot), rand_box(kind),
					COUNT_BITS'($urandom), IOU_BITS'($urandom), hold);
			end else begin
				if (pfx == MAX_TRACKS) begin
					// search past the table end once it is full
					if (!big_done) cnt = COUNT_TOP;
					else if ($urandom_range(0, 4) == 0) cnt = $urandom_range(MAX_TRACKS + 1, COUNT_TOP);
					else cnt = $urandom_range(0, MAX_TRACKS);
					big_done = 1'b1;
				end else begin
					cnt = $urandom_range(0, pfx);
				end
				pick = $urandom_range(0, 99);
				if (pfx > 0 && pick < 55) begin
					s = $urandom_range(0, pfx - 1);
					qb = planned_boxes[s];
					if (pick >= 10) begin
						qb.l = COORD_BITS'(int'(qb.l) + int'($urandom_range(0, 12)) - 6);
						qb.t = COORD_BITS'(int'(qb.t) + int'($urandom_range(0, 12)) - 6);
						qb.r = COORD_BITS'(int'(qb.r) + int'($urandom_range(0, 12)) - 6);
						qb.b = COORD_BITS'(int'(qb.b) + int'($urandom_range(0, 12)) - 6);
					end
				end else begin
					qb = rand_box(kind);
				end
				add_beat(MODE_QUERY, SLOT_BITS'($urandom), qb, COUNT_BITS'(cnt),
					rand_start(), hold);
			end
		end
		cycle_limit += 4 * TAIL_CYCLES;

		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!(beats_taken == beats_total && pending_matches.size() == 0)
			&& cycle_cnt < cycle_limit)
			@(posedge clk);
		if (cycle_cnt >= cycle_limit) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_cnt);
			$display("tb: failure");
		end else begin
			repeat (TAIL_CYCLES) @(posedge clk);
			if (err_cnt == 0)
				$display("tb: success");
			else
				$display("tb: failure");
		end
		$finish;
	end

endmodule
